### hdl/ccc_pkg.sv
// Shared types and constants for the cell centroid and color classifier.
package ccc_pkg;

    localparam int unsigned DataW       = 32;
    localparam int unsigned InTdataW    = 200;
    localparam int unsigned OutTdataW   = 168;
    localparam int unsigned BitsPerStep = 2;
    localparam int unsigned DivSteps    = DataW / BitsPerStep;
    localparam int unsigned StepW       = $clog2(DivSteps);

    // floor(x/3) = (x * Recip3) >> Recip3Shift for any 32-bit x
    localparam logic [DataW-1:0] Recip3      = 32'hAAAA_AAAB;
    localparam int unsigned      Recip3Shift = 33;

    typedef enum logic [2:0] {
        REG_MIN_COUNT = 3'd0,
        REG_BLK_RED   = 3'd1,
        REG_BLK_GRN   = 3'd2,
        REG_BLK_BLU   = 3'd3,
        REG_YEL_GRN   = 3'd4,
        REG_YEL_RED   = 3'd5
    } t_cfg_reg;

    // divider operations, run in this order
    typedef enum logic [2:0] {
        OP_COL = 3'd0,
        OP_ROW = 3'd1,
        OP_RED = 3'd2,
        OP_GRN = 3'd3,
        OP_BLU = 3'd4
    } t_op;

    localparam t_op OP_LAST = OP_BLU;

    typedef enum logic [2:0] {
        CLS_NONE    = 3'd0,
        CLS_BLACK   = 3'd1,
        CLS_RED     = 3'd2,
        CLS_YELLOW  = 3'd3,
        CLS_GREEN   = 3'd4,
        CLS_BLUE    = 3'd5,
        CLS_COLORED = 3'd6
    } t_class;

    typedef struct packed {
        logic [2:0]       cell_index;
        logic [DataW-1:0] pixel_count;
        logic [DataW-1:0] sum_col;
        logic [DataW-1:0] sum_row;
        logic [DataW-1:0] sum_red;
        logic [DataW-1:0] sum_green;
        logic [DataW-1:0] sum_blue;
        logic             scan_last;
    } t_ccc_item;

    typedef struct packed {
        logic [2:0]       cell_out;
        logic             dot_present;
        logic [DataW-1:0] centre_col;
        logic [DataW-1:0] centre_row;
        logic [DataW-1:0] mean_red;
        logic [DataW-1:0] mean_green;
        logic [DataW-1:0] mean_blue;
        t_class           color_class;
        logic             scan_done;
        logic             no_dot_in_scan;
    } t_ccc_result;

    typedef struct packed {
        logic capture;
        logic div_load;
        logic div_step;
        logic div_store;
        logic emit;
        t_op  op;
    } t_ccc_cmd;

    typedef struct packed {
        logic dot;
        logic out_free;
    } t_ccc_sts;

endpackage

### hdl/ccc_ctrl.sv
// Sequencer: input acceptance, division schedule and result hand-off.
module ccc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ccc_pkg::t_ccc_sts i_sts,
    output ccc_pkg::t_ccc_cmd o_cmd
);
    import ccc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_LOAD   = 5'b00010,
        S_DIV    = 5'b00100,
        S_NEXT   = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    t_state           r_state, n_state;
    t_op              r_op, n_op;
    logic [StepW-1:0] r_step, n_step;

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_step     = r_step;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.op   = OP_COL;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_LOAD;
                end
            end
            S_LOAD: begin
                if (i_sts.dot) begin
                    o_cmd.div_load = 1'b1;
                    o_cmd.op       = OP_COL;
                    n_op           = OP_COL;
                    n_step         = '0;
                    n_state        = S_DIV;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + StepW'(1);
                if (r_step == StepW'(DivSteps - 1)) begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                o_cmd.div_store = 1'b1;
                if (r_op == OP_LAST) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.div_load = 1'b1;
                    o_cmd.op       = t_op'(r_op + 3'd1);
                    n_op           = t_op'(r_op + 3'd1);
                    n_step         = '0;
                    n_state        = S_DIV;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_COL;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_step  <= n_step;
        end
    end

endmodule

### hdl/ccc_dp.sv
// Datapath: config registers, operand capture, shared divider, classifier, output register.
module ccc_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [2:0]                     i_cfg_index,
    input  logic [ccc_pkg::DataW-1:0]      i_cfg_data,
    input  ccc_pkg::t_ccc_item             i_item,
    input  ccc_pkg::t_ccc_cmd              i_cmd,
    output ccc_pkg::t_ccc_sts              o_sts,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output ccc_pkg::t_ccc_result           o_result
);
    import ccc_pkg::*;

    logic [DataW-1:0] r_min_count, r_blk_red, r_blk_grn, r_blk_blu, r_yel_grn, r_yel_red;

    logic [2:0]       r_cell;
    logic [DataW-1:0] r_count;
    logic [DataW-1:0] r_sum [5];
    logic             r_last;
    logic             r_dot;
    logic             r_seen;

    logic [DataW-1:0] r_num, n_num;
    logic [DataW-1:0] r_rem, n_rem;
    logic [DataW-1:0] r_divisor;
    t_op              r_sel;
    logic [DataW-1:0] r_quot [5];
    logic [DataW-1:0] r_g3_q;

    logic             r_out_valid;
    t_ccc_result      r_out;

    logic [DataW-1:0]   load_num;
    logic [2*DataW-1:0] g3_prod;
    logic [1:0]         g3_rem;
    logic [DataW:0]     g23;
    t_class             cls;
    logic               seen_all;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_count <= DataW'(20);
            r_blk_red   <= DataW'(10);
            r_blk_grn   <= DataW'(20);
            r_blk_blu   <= DataW'(10);
            r_yel_grn   <= DataW'(30);
            r_yel_red   <= DataW'(15);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MIN_COUNT: r_min_count <= i_cfg_data;
                REG_BLK_RED:   r_blk_red   <= i_cfg_data;
                REG_BLK_GRN:   r_blk_grn   <= i_cfg_data;
                REG_BLK_BLU:   r_blk_blu   <= i_cfg_data;
                REG_YEL_GRN:   r_yel_grn   <= i_cfg_data;
                REG_YEL_RED:   r_yel_red   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cell   <= i_item.cell_index;
            r_count  <= i_item.pixel_count;
            r_sum[0] <= i_item.sum_col;
            r_sum[1] <= i_item.sum_row;
            r_sum[2] <= i_item.sum_red;
            r_sum[3] <= i_item.sum_green;
            r_sum[4] <= i_item.sum_blue;
            r_last   <= i_item.scan_last;
            r_dot    <= i_item.pixel_count > r_min_count;
        end
    end

    // operand select
    always_comb begin
        unique case (i_cmd.op)
            OP_COL:  load_num = r_sum[0];
            OP_ROW:  load_num = r_sum[1];
            OP_RED:  load_num = r_sum[2];
            OP_GRN:  load_num = r_sum[3];
            OP_BLU:  load_num = r_sum[4];
            default: load_num = r_sum[0];
        endcase
    end

    // restoring divider, BitsPerStep quotient bits per cycle
    always_comb begin
        logic [DataW-1:0] rem_v;
        logic [DataW-1:0] num_v;
        logic [DataW:0]   trial;
        rem_v = r_rem;
        num_v = r_num;
        trial = '0;
        for (int k = 0; k < BitsPerStep; k++) begin
            trial = {rem_v, num_v[DataW-1]};
            num_v = {num_v[DataW-2:0], 1'b0};
            if (trial >= {1'b0, r_divisor}) begin
                trial    = trial - {1'b0, r_divisor};
                num_v[0] = 1'b1;
            end
            rem_v = trial[DataW-1:0];
        end
        n_rem = rem_v;
        n_num = num_v;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_num     <= load_num;
            r_rem     <= '0;
            r_sel     <= i_cmd.op;
            r_divisor <= r_count;
        end else if (i_cmd.div_step) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
        if (i_cmd.div_store) begin
            unique case (r_sel)
                OP_COL: r_quot[0] <= r_num;
                OP_ROW: r_quot[1] <= r_num;
                OP_RED: r_quot[2] <= r_num;
                OP_GRN: r_quot[3] <= r_num;
                OP_BLU: r_quot[4] <= r_num;
                default: ;
            endcase
        end
    end

    // g/3 by reciprocal multiply; settles while the blue division runs
    assign g3_prod = (2*DataW)'(r_quot[3]) * (2*DataW)'(Recip3);

    always_ff @(posedge i_clk) begin
        r_g3_q <= DataW'(g3_prod[2*DataW-1:Recip3Shift]);
    end

    // g - 3*(g/3) is below four, so its low two bits are the remainder
    assign g3_rem = r_quot[3][1:0] - (r_g3_q[1:0] + {r_g3_q[0], 1'b0});

    // floor(2g/3) = 2*(g/3) + (remainder is two)
    assign g23 = {r_g3_q, 1'b0} + (DataW+1)'(g3_rem == 2'd2);

    always_comb begin
        priority if (r_quot[2] < r_blk_red && r_quot[3] < r_blk_grn
                     && r_quot[4] < r_blk_blu) begin
            cls = CLS_BLACK;
        end else if ({1'b0, r_quot[2]} > g23 && r_quot[2] > r_quot[4]) begin
            cls = (r_quot[3] > r_yel_grn && r_quot[2] > r_yel_red) ? CLS_YELLOW : CLS_RED;
        end else if ({1'b0, r_quot[3]} > {r_quot[2], 1'b0}
                     && {1'b0, r_quot[3]} > {r_quot[4], 1'b0}) begin
            cls = CLS_GREEN;
        end else if (r_quot[4] > r_quot[2] && {1'b0, r_quot[4]} > g23) begin
            cls = CLS_BLUE;
        end else begin
            cls = CLS_COLORED;
        end
    end

    assign seen_all = r_seen | r_dot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_seen      <= r_last ? 1'b0 : seen_all;
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.cell_out       <= r_cell;
            r_out.dot_present    <= r_dot;
            r_out.centre_col     <= r_dot ? r_quot[0] : '0;
            r_out.centre_row     <= r_dot ? r_quot[1] : '0;
            r_out.mean_red       <= r_dot ? r_quot[2] : '0;
            r_out.mean_green     <= r_dot ? r_quot[3] : '0;
            r_out.mean_blue      <= r_dot ? r_quot[4] : '0;
            r_out.color_class    <= r_dot ? cls : CLS_NONE;
            r_out.scan_done      <= r_last;
            r_out.no_dot_in_scan <= r_last & ~seen_all;
        end
    end

    assign o_sts.dot      = r_dot;
    assign o_sts.out_free = ~r_out_valid | i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_result       = r_out;

endmodule

### hdl/cell_centroid_color_classifier_top.sv
// Cell centroid and color classifier, top level.
// A cell with a dot runs its five divisions and then waits for a free output register;
// one without a dot skips them. The next cell is taken in the cycle after the hand-off.
// Five 32-bit divisions share one divider that retires two quotient bits per cycle.
// The output register frees the divider while a result waits on the master side.
// Synchronous active-low reset restores the register defaults, clears the dot-seen flag and the output valid.
module cell_centroid_color_classifier_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [2:0]                      i_cfg_index,
    input  logic [ccc_pkg::DataW-1:0]       i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // cell_index, pixel_count, sum_col, sum_row, sum_red, sum_green, sum_blue, zero pad
    input  logic [ccc_pkg::InTdataW-1:0]    s_axis_tdata,
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // cell_out, dot_present, centre_col, centre_row, mean_red, mean_green,
    // mean_blue, color_class, no_dot_in_scan
    output logic [ccc_pkg::OutTdataW-1:0]   m_axis_tdata,
    output logic                            m_axis_tlast
);
    import ccc_pkg::*;

    t_ccc_item   item;
    t_ccc_result result;
    t_ccc_cmd    cmd;
    t_ccc_sts    sts;

    assign item.cell_index  = s_axis_tdata[2:0];
    assign item.pixel_count = s_axis_tdata[34:3];
    assign item.sum_col     = s_axis_tdata[66:35];
    assign item.sum_row     = s_axis_tdata[98:67];
    assign item.sum_red     = s_axis_tdata[130:99];
    assign item.sum_green   = s_axis_tdata[162:131];
    assign item.sum_blue    = s_axis_tdata[194:163];
    assign item.scan_last   = s_axis_tlast;

    assign o_cfg_ready = 1'b1;

    ccc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ccc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (item),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_result    (result)
    );

    assign m_axis_tdata = {result.no_dot_in_scan, result.color_class, result.mean_blue,
                           result.mean_green, result.mean_red, result.centre_row,
                           result.centre_col, result.dot_present, result.cell_out};
    assign m_axis_tlast = result.scan_done;

endmodule
